### rtl/ncq_pkg.sv
package ncq_pkg;

	localparam int MAX_DIMS      = 128;
	localparam int MAX_CENTROIDS = 256;
	localparam int ELEMENT_BITS  = 16;
	localparam int DIM_BITS      = $clog2(MAX_DIMS);
	localparam int CENT_BITS     = $clog2(MAX_CENTROIDS);
	localparam int STORE_DEPTH   = MAX_DIMS * MAX_CENTROIDS;
	localparam int SQ_BITS       = 2 * ELEMENT_BITS;
	localparam int ACC_BITS      = 40;
	localparam int DIST_BITS     = 39;

	localparam int DIMS_REG_BITS = 8;
	localparam int CENT_REG_BITS = 9;
	localparam int CFG_DATA_BITS = 9;

	localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_DIMS      = 1'b0,
		REG_CENTROIDS = 1'b1
	} cfg_reg_t;

	// One issue slot of the accumulator sweep.
	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic                 add;
		logic                 in_range;
		logic [CENT_BITS-1:0] idx;
	} mac_ctl_t;

	typedef struct packed {
		logic                 busy;
		logic [CENT_BITS-1:0] best_idx;
		logic [ACC_BITS-1:0]  best_dist;
	} mac_stat_t;

endpackage

### rtl/ncq_ram.sv
module ncq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

### rtl/ncq_mac.sv
module ncq_mac
	import ncq_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctl_t                       ctl,
	input  logic signed [ELEMENT_BITS-1:0] value,
	input  logic signed [ELEMENT_BITS-1:0] cent_rd,
	output mac_stat_t                      stat
);

	mac_ctl_t ctl_s1, ctl_s2, ctl_s3;

	logic [ELEMENT_BITS-1:0] mag_s2;
	logic [ACC_BITS-1:0]     acc_s2, acc_s3;
	logic [SQ_BITS-1:0]      sq_s3;
	logic [ACC_BITS-1:0]     acc_rd;
	logic [ACC_BITS-1:0]     best_q;
	logic [CENT_BITS-1:0]    best_idx_q;

	logic signed [ELEMENT_BITS:0] diff, diff_neg;
	logic [ELEMENT_BITS-1:0]      mag;
	logic [ACC_BITS-1:0]          base, new_acc, cmp_best;
	logic [ACC_BITS:0]            sum;
	logic [CENT_BITS-1:0]         cmp_idx;
	logic                         take;

	ncq_ram #(
		.WIDTH(ACC_BITS),
		.DEPTH(MAX_CENTROIDS)
	) u_acc_ram (
		.clk  (clk),
		.we   (ctl_s3.valid),
		.waddr(ctl_s3.idx),
		.wdata(new_acc),
		.raddr(ctl.idx),
		.rdata(acc_rd)
	);

	// Stage 1: difference and magnitude against the centroid element.
	always_comb begin
		diff     = {value[ELEMENT_BITS-1], value} - {cent_rd[ELEMENT_BITS-1], cent_rd};
		diff_neg = -diff;
		mag      = diff[ELEMENT_BITS] ? diff_neg[ELEMENT_BITS-1:0]
		                              : diff[ELEMENT_BITS-1:0];
	end

	// Stage 3: saturating accumulate and running minimum.
	always_comb begin
		base    = ctl_s3.first ? '0 : acc_s3;
		sum     = {1'b0, base} + (ACC_BITS+1)'(ctl_s3.add ? sq_s3 : '0);
		new_acc = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
		cmp_best = (ctl_s3.idx == '0) ? ACC_MAX : best_q;
		cmp_idx  = (ctl_s3.idx == '0) ? '0 : best_idx_q;
		take     = ctl_s3.in_range && (new_acc < cmp_best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag;
		acc_s2 <= acc_rd;
		acc_s3 <= acc_s2;
		sq_s3  <= SQ_BITS'(mag_s2) * SQ_BITS'(mag_s2);
		if (ctl_s3.valid) begin
			best_q     <= take ? new_acc : cmp_best;
			best_idx_q <= take ? ctl_s3.idx : cmp_idx;
		end
	end

	assign stat.busy      = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid;
	assign stat.best_idx  = best_idx_q;
	assign stat.best_dist = best_q;

	// The sweep writes the accumulators in ascending order with no gaps.
	a_sweep_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.idx != '0 |->
			$past(ctl_s3.valid) && ctl_s3.idx == $past(ctl_s3.idx) + 1'b1)
		else $error("accumulator sweep out of order");

	a_first_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.idx == '0 |-> ctl_s3.in_range)
		else $error("centroid 0 not in range");

endmodule

### rtl/nearest_centroid_quantizer_unit.sv
// Nearest-centroid L2 quantizer. Centroid elements (tuser = 0) are written into a
// 256 x 128 table of 16-bit signed values, one per cycle while the unit is idle. Query elements
// (tuser = 1) run one pass of a single shared subtract-square-accumulate unit over
// all 256 distance accumulators, one centroid per cycle, so a query element holds
// tready low through the sweep and the drain of the accumulator pipeline, and the
// next element can transfer only once both are done. The drain lasts longer while a
// finished result waits for a full output register to empty. The
// element marked by tlast ends the query and yields the index of the nearest
// centroid among the first centroids_in_use (lowest index on a tie) and its
// squared distance, saturated to 39 bits. The first query element after reset or
// after a result starts the accumulators from zero, so no clearing pass is needed.
// Centroid entries must be written before a query reads them.
module nearest_centroid_quantizer_unit
	import ncq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// centroid_index [7:0], element_index [14:8], element_value [30:15], zero fill
	input  logic [31:0]              s_tdata,
	// command
	input  logic                     s_tuser,
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// nearest_index [7:0], nearest_distance [46:8], zero fill
	output logic [47:0]              m_tdata,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t state_q;

	logic [DIMS_REG_BITS-1:0] dims_q;
	logic [CENT_REG_BITS-1:0] ncent_q;
	logic [DIMS_REG_BITS-1:0] dims_eff;
	logic [CENT_REG_BITS-1:0] ncent_eff;

	logic [CENT_BITS-1:0]          cnt_q;
	logic                          query_open_q;
	logic signed [ELEMENT_BITS-1:0] value_q;
	logic [DIM_BITS-1:0]           eidx_q;
	logic                          last_q;
	logic                          first_q;
	logic                          add_q;

	logic                 m_tvalid_q;
	logic [CENT_BITS-1:0] m_index_q;
	logic [DIST_BITS-1:0] m_dist_q;

	logic [CENT_BITS-1:0]           in_cidx;
	logic [DIM_BITS-1:0]            in_eidx;
	logic signed [ELEMENT_BITS-1:0] in_value;
	cmd_t                           in_cmd;
	logic                           in_accept;
	logic                           store_we;
	logic signed [ELEMENT_BITS-1:0] cent_rd;
	mac_ctl_t                       mac_ctl;
	mac_stat_t                      mac_stat;
	logic [DIST_BITS-1:0]           dist_sat;
	logic                           res_load;

	assign in_cidx   = s_tdata[7:0];
	assign in_eidx   = s_tdata[14:8];
	assign in_value  = s_tdata[30:15];
	assign in_cmd    = cmd_t'(s_tuser);
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign store_we  = in_accept && (in_cmd == CMD_WRITE);

	// A register value of zero acts as one, values above the maximum as the maximum.
	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DIMS_REG_BITS'(1);
		end else if (dims_q > DIMS_REG_BITS'(MAX_DIMS)) begin
			dims_eff = DIMS_REG_BITS'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
		if (ncent_q == '0) begin
			ncent_eff = CENT_REG_BITS'(1);
		end else if (ncent_q > CENT_REG_BITS'(MAX_CENTROIDS)) begin
			ncent_eff = CENT_REG_BITS'(MAX_CENTROIDS);
		end else begin
			ncent_eff = ncent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_REG_BITS'(MAX_DIMS);
			ncent_q <= CENT_REG_BITS'(MAX_CENTROIDS);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIMS:      dims_q  <= cfg_data[DIMS_REG_BITS-1:0];
				REG_CENTROIDS: ncent_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	ncq_ram #(
		.WIDTH(ELEMENT_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr({in_cidx, in_eidx}),
		.wdata(in_value),
		.raddr({cnt_q, eidx_q}),
		.rdata(cent_rd)
	);

	always_comb begin
		mac_ctl.valid    = (state_q == ST_SWEEP);
		mac_ctl.first    = first_q;
		mac_ctl.add      = add_q;
		mac_ctl.in_range = {1'b0, cnt_q} < ncent_eff;
		mac_ctl.idx      = cnt_q;
	end

	ncq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.value  (value_q),
		.cent_rd(cent_rd),
		.stat   (mac_stat)
	);

	assign dist_sat = (mac_stat.best_dist > ACC_BITS'(DIST_MAX))
		? DIST_MAX : mac_stat.best_dist[DIST_BITS-1:0];

	assign res_load = (state_q == ST_DRAIN) && !mac_stat.busy && last_q
		&& (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			query_open_q <= 1'b0;
			value_q      <= '0;
			eidx_q       <= '0;
			last_q       <= 1'b0;
			first_q      <= 1'b0;
			add_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_index_q    <= '0;
			m_dist_q     <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && in_cmd == CMD_QUERY) begin
						value_q      <= in_value;
						eidx_q       <= in_eidx;
						last_q       <= s_tlast;
						first_q      <= !query_open_q;
						add_q        <= {1'b0, in_eidx} < dims_eff;
						query_open_q <= 1'b1;
						cnt_q        <= '0;
						state_q      <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CENT_BITS'(MAX_CENTROIDS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_stat.busy) begin
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (res_load) begin
							// The output register is free, or is emptied in this cycle.
							m_index_q    <= mac_stat.best_idx;
							m_dist_q     <= dist_sat;
							query_open_q <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_dist_q, m_index_q};

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mac_stat.busy)
		else $error("input taken while the accumulator pipeline is busy");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_cmd == CMD_QUERY |=> !s_tready)
		else $error("query element did not start a sweep");

	a_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $fell(query_open_q))
		else $error("result issued without closing the query");

endmodule
